// ===== hdl/eskm_pkg.sv =====
// Package for the escape sequence key matcher: table sizes, field widths,
// function and result codes, and the result record type.
// No dependencies.
package eskm_pkg;

    // Table dimensions.
    localparam int NUM_PATTERNS  = 12;
    localparam int PATTERN_BYTES = 20;

    localparam int ENTRY_IDX_W = $clog2(NUM_PATTERNS);
    localparam int POS_IDX_W   = $clog2(PATTERN_BYTES);

    // Field widths of the stream items.
    localparam int FUNC_W     = 2;
    localparam int ENTRY_W    = 4;
    localparam int POSITION_W = 5;
    localparam int VALUE_W    = 16;
    localparam int KIND_W     = 2;
    localparam int CODE_W     = 16;
    localparam int BYTE_W     = 8;

    // Packed stream widths; the tdata widths are padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = KIND_W;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ERASE_CHAR     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKSPACE_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PARITY_MASK    = 2'd2;

    localparam logic [BYTE_W-1:0] ERASE_CHAR_RST     = 8'd127;
    localparam logic [CODE_W-1:0] BACKSPACE_CODE_RST = 16'd8;
    localparam logic [BYTE_W-1:0] PARITY_MASK_RST    = 8'd127;

    // The ASCII backspace byte always counts as erase at sequence start.
    localparam logic [BYTE_W-1:0] ASCII_BS = 8'd8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_KEY     = 2'd0,
        FUNC_PATTERN = 2'd1,
        FUNC_KEYCODE = 2'd2
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PLAIN     = 2'd0,
        KIND_BACKSPACE = 2'd1,
        KIND_KEY       = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CODE_W-1:0] code;
    } result_t;

endpackage

// ===== hdl/escape_sequence_key_matcher.sv =====
// Top level of the escape sequence key matcher: match logic, pattern table,
// key code table and output skid stage. Depends on eskm_pkg.
//
// The block takes one beat per clock and matches keystroke bytes against a
// table of 12 escape strings of up to 20 bytes (a zero byte ends a string),
// each paired with a 16-bit key code. Every beat is finished in the cycle it is
// accepted: all entries are compared in parallel at the current sequence
// position, and the result, if any, lands in the output register (or in the skid
// register while the output is stalled); the sustained rate is one beat per
// cycle while s_tready is high. The pattern table is organized as one row per byte position, all
// entries side by side; the row for the position the next beat will see is
// read from the table on every edge, so the single read port is what holds a
// beat to one position per cycle. A two-entry output stage (output register
// plus skid register) lets the input side keep taking beats for one extra
// result while the output is stalled; s_tready drops only when both are full.
// Table write beats (func 1 pattern byte, func 2 key code) cancel any sequence
// in progress and give no result; func 3 is ignored. Configuration registers
// are written through cfg_we/cfg_index/cfg_wdata and must only change while
// the block is idle.
module escape_sequence_key_matcher (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: entry [3:0], position [8:4], value [24:9], zero above.
    input  logic [eskm_pkg::S_TDATA_W-1:0]        s_tdata,
    // s_tuser: func [1:0].
    input  logic [eskm_pkg::S_TUSER_W-1:0]        s_tuser,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: code [15:0].
    output logic [eskm_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: kind [1:0].
    output logic [eskm_pkg::M_TUSER_W-1:0]        m_tuser,

    input  logic                                  cfg_we,
    input  logic [eskm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [eskm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int NP  = eskm_pkg::NUM_PATTERNS;
    localparam int PB  = eskm_pkg::PATTERN_BYTES;
    localparam int EIW = eskm_pkg::ENTRY_IDX_W;
    localparam int PIW = eskm_pkg::POS_IDX_W;
    localparam int BW  = eskm_pkg::BYTE_W;
    localparam int CW  = eskm_pkg::CODE_W;

    // ------------------------------------------------------------------
    // Input field unpacking.
    // ------------------------------------------------------------------
    logic [eskm_pkg::ENTRY_W-1:0]    s_entry;
    logic [eskm_pkg::POSITION_W-1:0] s_position;
    logic [eskm_pkg::VALUE_W-1:0]    s_value;
    logic [BW-1:0]                   s_byte;

    assign s_entry    = s_tdata[3:0];
    assign s_position = s_tdata[8:4];
    assign s_value    = s_tdata[24:9];
    assign s_byte     = s_value[BW-1:0];

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [BW-1:0] erase_char_reg;
    logic [CW-1:0] backspace_code_reg;
    logic [BW-1:0] parity_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_char_reg     <= eskm_pkg::ERASE_CHAR_RST;
            backspace_code_reg <= eskm_pkg::BACKSPACE_CODE_RST;
            parity_mask_reg    <= eskm_pkg::PARITY_MASK_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                eskm_pkg::CFG_ERASE_CHAR: begin
                    erase_char_reg <= cfg_wdata[BW-1:0];
                end
                eskm_pkg::CFG_BACKSPACE_CODE: begin
                    backspace_code_reg <= cfg_wdata[CW-1:0];
                end
                eskm_pkg::CFG_PARITY_MASK: begin
                    parity_mask_reg <= cfg_wdata[BW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Beat decode.
    // ------------------------------------------------------------------
    logic s_fire;
    logic is_key;
    logic is_pat_wr;
    logic is_code_wr;
    logic entry_ok;
    logic pos_ok;
    logic pat_we;
    logic code_we;

    logic [EIW-1:0] wr_entry;
    logic [PIW-1:0] wr_pos;

    assign s_fire = s_tvalid && s_tready;

    always_comb begin
        is_key     = 1'b0;
        is_pat_wr  = 1'b0;
        is_code_wr = 1'b0;
        case (s_tuser)
            eskm_pkg::FUNC_KEY:     is_key     = 1'b1;
            eskm_pkg::FUNC_PATTERN: is_pat_wr  = 1'b1;
            eskm_pkg::FUNC_KEYCODE: is_code_wr = 1'b1;
            default: begin
            end
        endcase
    end

    assign entry_ok = ({1'b0, s_entry} < (eskm_pkg::ENTRY_W + 1)'(NP));
    assign pos_ok   = ({1'b0, s_position} < (eskm_pkg::POSITION_W + 1)'(PB));
    assign wr_entry = EIW'(s_entry);
    assign wr_pos   = PIW'(s_position);
    assign pat_we   = s_fire && is_pat_wr && entry_ok && pos_ok;
    assign code_we  = s_fire && is_code_wr && entry_ok;

    // ------------------------------------------------------------------
    // Match state.
    // ------------------------------------------------------------------
    logic [NP-1:0]  alive_reg;
    logic [NP-1:0]  alive_next;
    logic [PIW-1:0] pos_reg;
    logic [PIW-1:0] pos_next;

    // Pattern table: one row per byte position, one byte lane per entry.
    // A per-byte nonzero flag sits beside it in flops; a lane whose flag is
    // clear reads as a zero byte, which also covers the cleared table after
    // reset without a sweep.
    logic [NP-1:0][BW-1:0] pat_mem [PB];
    logic [NP-1:0][BW-1:0] row_reg;
    logic [NP-1:0]         nz_reg [PB];
    logic [CW-1:0]         key_code_reg [NP];

    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pat_mem[wr_pos][wr_entry] <= s_byte;
        end
        // Prefetch the row the next keystroke will be compared against. A
        // write to that same row in this cycle is forwarded into its lane.
        for (int e = 0; e < NP; e++) begin
            if (pat_we && (wr_pos == pos_next) && (wr_entry == EIW'(e))) begin
                row_reg[e] <= s_byte;
            end else begin
                row_reg[e] <= pat_mem[pos_next][e];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PB; p++) begin
                nz_reg[p] <= '0;
            end
            for (int e = 0; e < NP; e++) begin
                key_code_reg[e] <= '0;
            end
        end else begin
            if (pat_we) begin
                nz_reg[wr_pos][wr_entry] <= (s_byte != '0);
            end
            if (code_we) begin
                key_code_reg[wr_entry] <= s_value;
            end
        end
    end

    // ------------------------------------------------------------------
    // Parallel compare at the current position.
    // ------------------------------------------------------------------
    logic           at_start;
    logic [BW-1:0]  key_byte;
    logic           bs_hit;
    logic [PIW-1:0] pos_inc;
    logic           pos_last;
    logic [NP-1:0]  nz_cur;
    logic [NP-1:0]  nz_nxt;
    logic [NP-1:0]  eq_vec;
    logic [NP-1:0]  cont_vec;
    logic [NP-1:0]  hit_vec;
    logic           cont_any;
    logic           hit_any;
    logic [EIW-1:0] hit_idx;

    assign at_start = (pos_reg == '0);
    assign key_byte = at_start ? s_byte : (s_byte & parity_mask_reg);
    assign bs_hit   = at_start &&
                      ((s_byte == erase_char_reg) || (s_byte == eskm_pkg::ASCII_BS));
    assign pos_inc  = pos_reg + PIW'(1);
    assign pos_last = (pos_reg == PIW'(PB - 1));
    assign nz_cur   = nz_reg[pos_reg];
    assign nz_nxt   = pos_last ? '0 : nz_reg[pos_inc];

    // An entry still alive here has nonzero bytes up to this position; it
    // matches if this byte is nonzero and equal. It continues if the next
    // byte is also nonzero, otherwise this byte completes it.
    always_comb begin
        for (int e = 0; e < NP; e++) begin
            eq_vec[e]   = alive_reg[e] && nz_cur[e] && (row_reg[e] == key_byte);
            cont_vec[e] = eq_vec[e] && nz_nxt[e];
            hit_vec[e]  = eq_vec[e] && !nz_nxt[e];
        end
    end

    assign cont_any = |cont_vec;
    assign hit_any  = |hit_vec;

    // Lowest completed entry wins.
    always_comb begin
        hit_idx = '0;
        for (int e = NP - 1; e >= 0; e--) begin
            if (hit_vec[e]) begin
                hit_idx = EIW'(e);
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state and result.
    // ------------------------------------------------------------------
    eskm_pkg::result_t new_res;
    logic              new_valid;

    always_comb begin
        alive_next = alive_reg;
        pos_next   = pos_reg;
        new_valid  = 1'b0;
        new_res    = '{kind: eskm_pkg::KIND_PLAIN, code: CW'(key_byte)};
        if (s_fire) begin
            if (is_pat_wr || is_code_wr) begin
                alive_next = '1;
                pos_next   = '0;
            end else if (is_key) begin
                alive_next = '1;
                pos_next   = '0;
                new_valid  = 1'b1;
                if (bs_hit) begin
                    new_res.kind = eskm_pkg::KIND_BACKSPACE;
                    new_res.code = backspace_code_reg;
                end else if (cont_any) begin
                    alive_next = cont_vec;
                    pos_next   = pos_inc;
                    new_valid  = 1'b0;
                end else if (hit_any) begin
                    new_res.kind = eskm_pkg::KIND_KEY;
                    new_res.code = key_code_reg[hit_idx];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= '1;
            pos_reg   <= '0;
        end else begin
            alive_reg <= alive_next;
            pos_reg   <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid register behind it.
    // ------------------------------------------------------------------
    eskm_pkg::result_t out_reg;
    eskm_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              m_fire;

    assign m_fire   = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_fire) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (new_valid) begin
            if (!out_valid_reg || m_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_fire) begin
                out_reg <= skid_reg;
            end
        end else if (new_valid) begin
            if (!out_valid_reg || m_fire) begin
                out_reg <= new_res;
            end else begin
                skid_reg <= new_res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.code;
    assign m_tuser  = out_reg.kind;

endmodule

// ===== hdl/eskm_checker.sv =====
// Port-level checker for the escape sequence key matcher, bound to the top
// level. Depends on eskm_pkg and escape_sequence_key_matcher.
module eskm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [eskm_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [eskm_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [eskm_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [eskm_pkg::M_TUSER_W-1:0]   m_tuser,
    input logic                             cfg_we,
    input logic [eskm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [eskm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Back-pressure on the input only happens with a result waiting.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // A non-keystroke beat (table write or func 3) into an empty output stage produces nothing.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != eskm_pkg::FUNC_KEY) && !m_tvalid
        |=> !m_tvalid)
        else $error("result from a non-keystroke beat");

    // A plain byte result carries only a byte.
    a_plain_is_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == eskm_pkg::KIND_PLAIN) |-> (m_tdata[15:8] == 8'd0))
        else $error("plain result wider than a byte");

endmodule

bind escape_sequence_key_matcher eskm_checker u_eskm_checker (.*);

// ===== tb/tb_escape_sequence_key_matcher.sv =====
// Self-checking testbench for the escape sequence key matcher: a small checker class
// predicts every key result from the accepted input beats, plain tasks drive the input side.
// Depends on eskm_pkg and the escape_sequence_key_matcher top level.
module tb_escape_sequence_key_matcher;
    import eskm_pkg::*;

    // Run limit in time units; the slowest correct run needs well under a tenth of it.
    localparam int RUN_LIMIT = 2_000_000;
    // The func code the block has to ignore.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // Cycles of receiver hold-off used to fill the block and stall its input.
    localparam int HOLD_CYCLES = 250;

    // Predicts the key results of the matcher and holds the ones still due.
    class key_match_checker;
        logic [BYTE_W-1:0] pat_table [NUM_PATTERNS][PATTERN_BYTES];
        logic [CODE_W-1:0] key_table [NUM_PATTERNS];
        logic [NUM_PATTERNS-1:0] alive;
        int unsigned seq_pos;
        logic [BYTE_W-1:0] erase_byte;
        logic [CODE_W-1:0] bs_code;
        logic [BYTE_W-1:0] par_mask;
        result_t pending_keys [$];
        int mismatches;

        function new();
            for (int e = 0; e < NUM_PATTERNS; e++) begin
                key_table[e] = '0;
                for (int p = 0; p < PATTERN_BYTES; p++) begin
                    pat_table[e][p] = '0;
                end
            end
            erase_byte = ERASE_CHAR_RST;
            bs_code    = BACKSPACE_CODE_RST;
            par_mask   = PARITY_MASK_RST;
            mismatches = 0;
            restart_match();
        endfunction

        function void restart_match();
            alive   = '1;
            seq_pos = 0;
        endfunction

        // A string ends at its first zero byte, or fills the whole row.
        function int entry_length(int e);
            int n;
            n = 0;
            while (n < PATTERN_BYTES && pat_table[e][n] != 0) n++;
            return n;
        endfunction

        function void write_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ERASE_CHAR:     erase_byte = data[BYTE_W-1:0];
                CFG_BACKSPACE_CODE: bs_code    = data;
                CFG_PARITY_MASK:    par_mask   = data[BYTE_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_beat(logic [FUNC_W-1:0] func, logic [ENTRY_W-1:0] ent,
                                  logic [POSITION_W-1:0] posn, logic [VALUE_W-1:0] val);
            logic [BYTE_W-1:0] kb;
            logic [NUM_PATTERNS-1:0] cont;
            int hit;
            int len;
            kb   = val[BYTE_W-1:0];
            cont = '0;
            hit  = -1;
            case (func)
                FUNC_PATTERN: begin
                    if (ent < NUM_PATTERNS && posn < PATTERN_BYTES) pat_table[ent][posn] = kb;
                    restart_match();
                    return;
                end
                FUNC_KEYCODE: begin
                    if (ent < NUM_PATTERNS) key_table[ent] = val;
                    restart_match();
                    return;
                end
                FUNC_KEY: ;
                default: return;
            endcase

            // Erase or ASCII backspace only count as backspace at the start of a sequence.
            if (seq_pos == 0) begin
                if (kb == erase_byte || kb == ASCII_BS) begin
                    pending_keys.push_back('{kind: KIND_BACKSPACE, code: bs_code});
                    restart_match();
                    return;
                end
            end else begin
                kb = kb & par_mask;
            end

            for (int e = 0; e < NUM_PATTERNS; e++) begin
                if (alive[e]) begin
                    len = entry_length(e);
                    if (seq_pos < len && pat_table[e][seq_pos] == kb) begin
                        if (seq_pos + 1 < len) cont[e] = 1'b1;
                        else if (hit < 0) hit = e;
                    end
                end
            end

            // A longer entry still in play wins over one that completes here.
            if (cont != 0) begin
                alive   = cont;
                seq_pos = seq_pos + 1;
                return;
            end
            if (hit >= 0) pending_keys.push_back('{kind: KIND_KEY, code: key_table[hit]});
            else pending_keys.push_back('{kind: KIND_PLAIN, code: {8'h00, kb}});
            restart_match();
        endfunction

        function void check_key(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code);
            result_t want;
            if (pending_keys.size() == 0) begin
                $display("%0t: result with nothing due, actual kind %0d code %h",
                         $time, kind, code);
                mismatches++;
                return;
            end
            want = pending_keys.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind, kind);
                mismatches++;
            end
            if (code !== want.code) begin
                $display("%0t: code mismatch, expected %h actual %h", $time, want.code, code);
                mismatches++;
            end
        endfunction

        function int keys_outstanding();
            return pending_keys.size();
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    key_match_checker sb = new();

    int tx_idle_pct = 10;
    int rx_idle_pct = 10;
    int hold_requests = 0;

    escape_sequence_key_matcher uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Both handshakes are sampled at the rising edge, where every input is stable.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.accept_beat(s_tuser, s_tdata[3:0], s_tdata[8:4], s_tdata[24:9]);
            end
            if (m_tvalid && m_tready) sb.check_key(m_tuser, m_tdata);
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != served) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offers one beat, with a random idle cycle first, and returns at the edge that takes
    // it. Valid stays high afterwards, so back-to-back calls stream without a bubble.
    task automatic send_beat(logic [FUNC_W-1:0] func, logic [ENTRY_W-1:0] ent,
                             logic [POSITION_W-1:0] posn, logic [VALUE_W-1:0] val);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) gap = 1;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= func;
        s_tdata  <= {7'd0, val, posn, ent};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering beats and waits until every due result has come out. Table writes
    // give no result, so an extra wait at the end lets the last of them settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.keys_outstanding() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.write_config(idx, data);
    endtask

    initial begin
        int keys;
        int e;
        int p;
        int len;
        int stop;
        int r;
        int src;
        logic [BYTE_W-1:0] kb;
        logic [BYTE_W-1:0] erase_v;
        logic [BYTE_W-1:0] mask_v;
        logic [CODE_W-1:0] bs_v;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, with the reset configuration. Erase and ASCII backspace at the
        // start, a wide keystroke value on an empty table, and the unused func code.
        send_beat(FUNC_KEY, 4'h0, 5'h00, 16'h007F);
        send_beat(FUNC_KEY, 4'hF, 5'h1F, 16'hFF08);
        send_beat(FUNC_KEY, 4'h0, 5'h00, 16'hAB41);
        send_beat(FUNC_UNUSED, 4'hF, 5'h1F, 16'hFFFF);
        // Entry 0 is a prefix of entry 1; entries 2 and 3 are identical strings.
        send_beat(FUNC_PATTERN, 4'd0, 5'd0, 16'h001B);
        send_beat(FUNC_PATTERN, 4'd0, 5'd1, 16'h005B);
        send_beat(FUNC_KEYCODE, 4'd0, 5'd0, 16'hFFFF);
        send_beat(FUNC_PATTERN, 4'd1, 5'd0, 16'h001B);
        send_beat(FUNC_PATTERN, 4'd1, 5'd1, 16'h005B);
        send_beat(FUNC_PATTERN, 4'd1, 5'd2, 16'h0041);
        send_beat(FUNC_PATTERN, 4'd2, 5'd0, 16'h001B);
        send_beat(FUNC_PATTERN, 4'd2, 5'd1, 16'h004F);
        send_beat(FUNC_PATTERN, 4'd3, 5'd0, 16'h001B);
        send_beat(FUNC_PATTERN, 4'd3, 5'd1, 16'h004F);
        send_beat(FUNC_KEYCODE, 4'd3, 5'd0, 16'h1234);
        // Writes outside the table change nothing but still end a sequence.
        send_beat(FUNC_PATTERN, 4'hF, 5'h1F, 16'hFFFF);
        send_beat(FUNC_PATTERN, 4'd0, 5'd20, 16'h00AA);
        send_beat(FUNC_KEYCODE, 4'd12, 5'd0, 16'hFFFF);
        // Full match of the longer entry; the shorter one completing earlier is passed over.
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h001B);
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h005B);
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h0041);
        // Parity bit stripped after the first byte, then a miss gives the plain byte.
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h001B);
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h00DB);
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h0042);
        // Tie between two equal strings goes to the lower entry.
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h001B);
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h00CF);
        // The erase byte after the start is an ordinary byte.
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h001B);
        send_beat(FUNC_KEY, 4'd0, 5'd0, 16'h007F);

        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            case (phase)
                0: begin erase_v = 8'h00; bs_v = 16'h0000; mask_v = 8'hFF; end
                1: begin erase_v = 8'hFF; bs_v = 16'hFFFF; mask_v = 8'h7F; end
                2: begin erase_v = 8'($urandom); bs_v = 16'($urandom); mask_v = 8'h00; end
                3: begin erase_v = 8'h1B; bs_v = 16'($urandom); mask_v = 8'h7F; end
                4: begin erase_v = ASCII_BS; bs_v = 16'($urandom); mask_v = 8'hFF; end
                5: begin
                    erase_v = ERASE_CHAR_RST;
                    bs_v    = BACKSPACE_CODE_RST;
                    mask_v  = PARITY_MASK_RST;
                end
                default: begin erase_v = 8'($urandom); bs_v = 16'($urandom); mask_v = 8'($urandom); end
            endcase
            // The upper bits of the byte-wide registers carry noise that must be dropped.
            write_register(CFG_ERASE_CHAR, {8'($urandom), erase_v});
            write_register(CFG_BACKSPACE_CODE, bs_v);
            write_register(CFG_PARITY_MASK, {8'($urandom), mask_v});
            // One phase streams with no idling on either side.
            tx_idle_pct = (phase == 5) ? 0 : 10;
            rx_idle_pct = (phase == 5) ? 0 : 10;

            // On even phases, reload the whole table with escape-like strings: mostly short,
            // some empty, some that fill the row, and some copied from a lower entry so that
            // ties and prefixes come up.
            if (phase % 2 == 0) begin
                for (e = 0; e < NUM_PATTERNS; e++) begin
                    r = $urandom_range(19);
                    if (r == 0) len = 0;
                    else if (r == 1) len = 1;
                    else if (r == 2) len = PATTERN_BYTES;
                    else if (r == 3) len = PATTERN_BYTES - 1;
                    else len = $urandom_range(2, 6);
                    src = (e > 0 && $urandom_range(3) == 0) ? $urandom_range(e - 1) : -1;
                    // Stale bytes past the terminator must not count.
                    if (len + 1 < PATTERN_BYTES && $urandom_range(2) == 0) begin
                        send_beat(FUNC_PATTERN, 4'(e), 5'(len + 1),
                                  {8'($urandom), 8'($urandom_range(1, 255))});
                    end
                    for (p = 0; p < len; p++) begin
                        if (src >= 0 && p < sb.entry_length(src)) begin
                            kb = sb.pat_table[src][p];
                        end else if (p == 0) begin
                            kb = ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) : 8'h1B;
                        end else begin
                            case ($urandom_range(7))
                                0: kb = 8'h5B;
                                1: kb = 8'h4F;
                                2: kb = 8'h41 + 8'($urandom_range(3));
                                3: kb = 8'h30 + 8'($urandom_range(9));
                                4: kb = 8'h7E;
                                5: kb = 8'h3B;
                                default: kb = 8'($urandom_range(1, 255));
                            endcase
                        end
                        send_beat(FUNC_PATTERN, 4'(e), 5'(p), {8'($urandom), kb});
                    end
                    if (len < PATTERN_BYTES) begin
                        send_beat(FUNC_PATTERN, 4'(e), 5'(len), {8'($urandom), 8'h00});
                    end
                    send_beat(FUNC_KEYCODE, 4'(e), 5'($urandom), 16'($urandom));
                end
            end

            keys = 0;
            // Hold the result side off while random keystrokes keep coming, so the output
            // stage fills and the input side has to stall.
            if (phase == 4) begin
                hold_requests++;
                repeat (40) begin
                    send_beat(FUNC_KEY, 4'($urandom), 5'($urandom), 16'($urandom));
                    keys++;
                end
            end

            while (keys < 125) begin
                r = $urandom_range(99);
                if (r < 65) begin
                    // Follow a table entry, fully or up to a random point and then stray.
                    // Bits outside the parity mask are set at random after the first byte.
                    e    = $urandom_range(NUM_PATTERNS - 1);
                    len  = sb.entry_length(e);
                    stop = len;
                    if (len > 0 && $urandom_range(3) == 0) stop = $urandom_range(len - 1);
                    for (p = 0; p < stop; p++) begin
                        kb = sb.pat_table[e][p];
                        if (p > 0) kb = kb | (8'($urandom) & ~sb.par_mask);
                        send_beat(FUNC_KEY, 4'($urandom), 5'($urandom), {8'($urandom), kb});
                        keys++;
                    end
                    if (stop < len || len == 0) begin
                        send_beat(FUNC_KEY, 4'($urandom), 5'($urandom), 16'($urandom));
                        keys++;
                    end
                end else if (r < 80) begin
                    send_beat(FUNC_KEY, 4'($urandom), 5'($urandom), 16'($urandom));
                    keys++;
                end else if (r < 88) begin
                    kb = ($urandom_range(1) == 0) ? sb.erase_byte : ASCII_BS;
                    send_beat(FUNC_KEY, 4'($urandom), 5'($urandom), {8'($urandom), kb});
                    keys++;
                end else if (r < 93) begin
                    send_beat(FUNC_UNUSED, 4'($urandom), 5'($urandom), 16'($urandom));
                end else if (r < 97) begin
                    send_beat(FUNC_KEYCODE, 4'($urandom), 5'($urandom), 16'($urandom));
                    keys++;
                end else begin
                    send_beat(FUNC_PATTERN, 4'($urandom), 5'($urandom), 16'($urandom));
                    keys++;
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.keys_outstanding() == 0) begin
            $display("escape_sequence_key_matcher regression: pass");
        end else begin
            $display("escape_sequence_key_matcher regression: fail");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("escape_sequence_key_matcher regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/eskm_pkg.sv
hdl/escape_sequence_key_matcher.sv
hdl/eskm_checker.sv
tb/tb_escape_sequence_key_matcher.sv
